// ===== rtl/mlf_pkg.sv =====
// Shared types and constants for the match length factorizer.
package mlf_pkg;

  localparam int POS_W = 12;
  localparam int LEN_W = 12;
  localparam int RES_W = 13;

  // Command codes carried on the input selector.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // One write request into the match length memory.
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } wr_req_t;

  // One result item.
  typedef struct packed {
    logic             done_res;
    logic [RES_W-1:0] factor_count;
    logic [RES_W-1:0] factor_end;
  } res_t;

endpackage

// ===== rtl/mlf_len_mem.sv =====
// Match length memory: one write port, one registered read port with write bypass.
module mlf_len_mem #(
  parameter int MAX_TEXT = 4096,
  parameter int AW       = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mlf_pkg::wr_req_t           wr,
  input  logic [AW-1:0]              rd_addr,
  output logic [mlf_pkg::LEN_W-1:0]  rd_len
);

  logic [mlf_pkg::LEN_W-1:0] mem [MAX_TEXT];
  logic [mlf_pkg::LEN_W-1:0] rdata_r;
  logic [mlf_pkg::LEN_W-1:0] byp_r;
  logic                      byp_hit_r;
  logic                      wr_ok;
  logic [AW-1:0]             wr_addr;

  // Positions beyond the memory are dropped.
  assign wr_ok   = wr.en && (32'(wr.pos) < MAX_TEXT);
  assign wr_addr = AW'(wr.pos);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr.len;
    end
    rdata_r <= mem[rd_addr];
    byp_r   <= wr.len;
  end

  // A write to the entry being read in the same cycle wins over the stale read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= wr_ok && (wr_addr == rd_addr);
    end
  end

  assign rd_len = byp_hit_r ? byp_r : rdata_r;

endmodule

// ===== rtl/mlf_core.sv =====
// Load and walk control: rank bookkeeping, cursor update and memory requests.
module mlf_core #(
  parameter int MAX_TEXT = 4096,
  parameter int AW       = 12,
  parameter int CW       = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic                       command,
  input  logic [mlf_pkg::POS_W-1:0]  suffix_start,
  input  logic [mlf_pkg::LEN_W-1:0]  lcp_value,
  input  logic                       final_rank,
  input  logic [mlf_pkg::LEN_W-1:0]  rd_len,
  output mlf_pkg::wr_req_t           wr,
  output logic [AW-1:0]              rd_addr,
  output mlf_pkg::res_t              res,
  output logic                       busy
);

  localparam int SW = ((CW > mlf_pkg::LEN_W) ? CW : mlf_pkg::LEN_W) + 1;

  logic [mlf_pkg::POS_W-1:0] prior_start_r, prior_start_nxt;
  logic [mlf_pkg::LEN_W-1:0] prior_lcp_r, prior_lcp_nxt;
  logic [CW-1:0]             loaded_r, loaded_nxt;
  logic [CW-1:0]             cursor_r, cursor_nxt;
  logic [mlf_pkg::RES_W-1:0] factors_r, factors_nxt;
  logic                      sealed_r, sealed_nxt;
  logic                      pend_r, pend_nxt;
  logic [mlf_pkg::POS_W-1:0] pend_pos_r, pend_pos_nxt;
  logic [mlf_pkg::LEN_W-1:0] pend_len_r, pend_len_nxt;

  logic [CW-1:0]             lc_eff;
  logic [mlf_pkg::LEN_W-1:0] lcp_eff;
  logic [mlf_pkg::LEN_W-1:0] adv;
  logic [SW-1:0]             sum;

  always_comb begin
    prior_start_nxt = prior_start_r;
    prior_lcp_nxt   = prior_lcp_r;
    loaded_nxt      = loaded_r;
    cursor_nxt      = cursor_r;
    factors_nxt     = factors_r;
    sealed_nxt      = sealed_r;
    pend_nxt        = 1'b0;
    pend_pos_nxt    = pend_pos_r;
    pend_len_nxt    = pend_len_r;
    wr.en           = pend_r;
    wr.pos          = pend_pos_r;
    wr.len          = pend_len_r;
    res             = '0;
    lc_eff          = sealed_r ? '0 : loaded_r;
    lcp_eff         = (lc_eff == '0) ? '0 : lcp_value;
    adv             = (rd_len != '0) ? rd_len : mlf_pkg::LEN_W'(1);
    sum             = SW'(cursor_r) + SW'(adv);

    if (in_fire) begin
      case (command)
        mlf_pkg::CMD_LOAD: begin
          // A load after a finished text starts a new one.
          if (sealed_r) begin
            cursor_nxt  = '0;
            factors_nxt = '0;
            sealed_nxt  = 1'b0;
          end
          if (lc_eff != '0) begin
            wr.en  = 1'b1;
            wr.pos = prior_start_r;
            wr.len = (prior_lcp_r > lcp_value) ? prior_lcp_r : lcp_value;
          end
          prior_start_nxt = suffix_start;
          prior_lcp_nxt   = lcp_eff;
          loaded_nxt      = (32'(lc_eff) < MAX_TEXT) ? lc_eff + CW'(1) : lc_eff;
          if (final_rank) begin
            sealed_nxt = 1'b1;
            if (lc_eff != '0) begin
              // The write port is taken; the final rank's own entry goes next cycle.
              pend_nxt     = 1'b1;
              pend_pos_nxt = suffix_start;
              pend_len_nxt = lcp_eff;
            end else begin
              wr.en  = 1'b1;
              wr.pos = suffix_start;
              wr.len = lcp_eff;
            end
          end
          res.factor_end   = '0;
          res.factor_count = factors_nxt;
          res.done_res     = 1'b0;
        end
        mlf_pkg::CMD_STEP: begin
          if (sealed_r && (cursor_r < loaded_r)) begin
            cursor_nxt  = (sum > SW'(loaded_r)) ? loaded_r : CW'(sum);
            factors_nxt = factors_r + mlf_pkg::RES_W'(1);
          end
          res.factor_end   = mlf_pkg::RES_W'(cursor_nxt);
          res.factor_count = factors_nxt;
          res.done_res     = sealed_r && (cursor_nxt >= loaded_r);
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_start_r <= '0;
      prior_lcp_r   <= '0;
      loaded_r      <= '0;
      cursor_r      <= '0;
      factors_r     <= '0;
      sealed_r      <= 1'b0;
      pend_r        <= 1'b0;
    end else begin
      prior_start_r <= prior_start_nxt;
      prior_lcp_r   <= prior_lcp_nxt;
      loaded_r      <= loaded_nxt;
      cursor_r      <= cursor_nxt;
      factors_r     <= factors_nxt;
      sealed_r      <= sealed_nxt;
      pend_r        <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_pos_r <= pend_pos_nxt;
    pend_len_r <= pend_len_nxt;
  end

  // The memory is read at the next cursor every cycle, so a step finds its length ready.
  assign rd_addr = cursor_nxt[AW-1:0];
  assign busy    = pend_r;

endmodule

// ===== rtl/match_length_factorizer.sv =====
// Top level of the match length factorizer: stream ports, result register, core and memory.
//
// A user first loads the suffix array in rank order (tuser = 0), marking the last rank with
// tlast, and then issues step requests (tuser = 1), each of which returns the next factor end,
// the running factor count and a done flag; every request returns exactly one result. One
// request is taken per cycle unless the output stalls. The exception is a final rank that
// follows earlier ranks: it makes two writes to the single write port of the match length
// memory and holds off the next request meanwhile. A step takes its match length from a read
// of that memory issued at the new cursor in the cycle before, with a write bypass for an entry
// written in that same cycle, so consecutive steps run back to back. The memory has no clearing
// pass and is usable right after reset; entries read before being written are undefined.
module match_length_factorizer #(
  parameter int MAX_TEXT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] suffix_start, [23:12] lcp_value
  input  logic        in_tuser,   // command
  input  logic        in_tlast,   // final_rank
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [12:0] factor_end, [25:13] factor_count, [26] done_res
);

  localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int CW = $clog2(MAX_TEXT + 1);

  mlf_pkg::wr_req_t wr;
  mlf_pkg::res_t    res;
  logic [AW-1:0]    rd_addr;
  logic [mlf_pkg::LEN_W-1:0] rd_len;
  logic             busy;
  logic             in_fire;

  logic             out_valid_r, out_valid_nxt;
  mlf_pkg::res_t    out_res_r;

  // A new request may enter while the held result is taken in the same cycle.
  assign in_tready = !busy && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  mlf_core #(
    .MAX_TEXT (MAX_TEXT),
    .AW       (AW),
    .CW       (CW)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .command      (in_tuser),
    .suffix_start (in_tdata[11:0]),
    .lcp_value    (in_tdata[23:12]),
    .final_rank   (in_tlast),
    .rd_len       (rd_len),
    .wr           (wr),
    .rd_addr      (rd_addr),
    .res          (res),
    .busy         (busy)
  );

  mlf_len_mem #(
    .MAX_TEXT (MAX_TEXT),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_len  (rd_len)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.done_res, out_res_r.factor_count, out_res_r.factor_end};

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking stream testbench for the match length factorizer.
module tb_top;

  localparam int MAX_TEXT     = 4096;
  localparam int POS_W        = mlf_pkg::POS_W;
  localparam int LEN_W        = mlf_pkg::LEN_W;
  localparam int RES_W        = mlf_pkg::RES_W;
  localparam int RANDOM_ITEMS = 750;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [11:0] suffix_start, [23:12] lcp_value
  logic        in_tuser;   // command
  logic        in_tlast;   // final_rank
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [12:0] factor_end, [25:13] factor_count, [26] done_res

  bit idling;
  int quiet_cycles;
  int requests_sent;
  int texts_loaded;
  int longest_text;

  // Tracks the stored match lengths and the walk, and holds the results still owed.
  class factor_scoreboard;
    logic [LEN_W-1:0] lengths [MAX_TEXT];
    bit               written [MAX_TEXT];
    logic [POS_W-1:0] prev_start;
    logic [LEN_W-1:0] prev_lcp;
    int unsigned      ranks;
    int unsigned      walk_pos;
    int unsigned      factors;
    bit               sealed;
    mlf_pkg::res_t    owed_q [$];
    int               errors;
    int               checked;

    function new();
      prev_start = '0;
      prev_lcp = '0;
    endfunction

    function void store_length(logic [POS_W-1:0] pos, logic [LEN_W-1:0] len);
      lengths[pos] = len;
      written[pos] = 1'b1;
    endfunction

    // A step must never read an entry that was not written since reset.
    function bit step_is_safe();
      return !(sealed && walk_pos < ranks && !written[walk_pos]);
    endfunction

    function bit walk_done();
      return sealed && walk_pos >= ranks;
    endfunction

    function void note_request(logic cmd, logic [POS_W-1:0] start, logic [LEN_W-1:0] lcp,
                               logic last);
      mlf_pkg::res_t want;
      int unsigned   len;
      want = '0;
      if (cmd == mlf_pkg::CMD_LOAD) begin
        // A load after the final rank begins a new text; stored lengths survive.
        if (sealed) begin
          ranks = 0;
          walk_pos = 0;
          factors = 0;
          sealed = 1'b0;
        end
        if (ranks == 0) lcp = '0;
        else store_length(prev_start, (prev_lcp > lcp) ? prev_lcp : lcp);
        prev_start = start;
        prev_lcp = lcp;
        if (ranks < MAX_TEXT) ranks++;
        if (last) begin
          store_length(start, lcp);
          sealed = 1'b1;
        end
      end else begin
        if (sealed && walk_pos < ranks) begin
          len = lengths[walk_pos];
          walk_pos += (len != 0) ? len : 1;
          if (walk_pos > ranks) walk_pos = ranks;
          factors++;
        end
        want.factor_end = walk_pos[RES_W-1:0];
        want.done_res = sealed && walk_pos >= ranks;
      end
      want.factor_count = factors[RES_W-1:0];
      owed_q.push_back(want);
    endfunction

    task report_mismatch(string what, int unsigned got_val, int unsigned want_val);
      errors++;
      $display("%0t: %s got %0d, expected %0d", $time, what, got_val, want_val);
    endtask

    task check_result(logic [31:0] data);
      mlf_pkg::res_t got;
      mlf_pkg::res_t want;
      got = data[$bits(mlf_pkg::res_t)-1:0];
      checked++;
      if (owed_q.size() == 0) begin
        report_mismatch("result with nothing owed, factor_end", got.factor_end, 0);
        return;
      end
      want = owed_q.pop_front();
      if (got.factor_end !== want.factor_end)
        report_mismatch("factor_end", got.factor_end, want.factor_end);
      if (got.factor_count !== want.factor_count)
        report_mismatch("factor_count", got.factor_count, want.factor_count);
      if (got.done_res !== want.done_res)
        report_mismatch("done_res", got.done_res, want.done_res);
    endtask
  endclass

  factor_scoreboard sb = new();

  match_length_factorizer #(.MAX_TEXT(MAX_TEXT)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic cmd, input logic [POS_W-1:0] start,
                              input logic [LEN_W-1:0] lcp, input logic last);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {lcp, start};
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, start, lcp, last);
    requests_sent++;
    @(negedge clk);
  endtask

  // The load fields ride along with random content; a step ignores them.
  task automatic send_step();
    send_request(mlf_pkg::CMD_STEP, POS_W'($urandom), LEN_W'($urandom), 1'($urandom));
  endtask

  function automatic logic [LEN_W-1:0] pick_lcp(int n, bit wide);
    int roll;
    roll = wide ? 19 : $urandom_range(0, 19);
    if (roll < 10) return LEN_W'($urandom_range(0, 3));
    if (roll < 17) return LEN_W'($urandom_range(0, (n < 4095) ? n : 4095));
    return LEN_W'($urandom_range(0, 4095));
  endfunction

  // Loads a shuffled suffix array of n ranks, then walks it, fully or in part.
  task automatic load_and_walk(input int n, input bit wide);
    int perm [MAX_TEXT];
    int j;
    int tmp;
    int steps_left;
    bit full_walk;
    for (int i = 0; i < n; i++) perm[i] = i % MAX_TEXT;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      // A step between ranks of an unfinished text must leave the walk alone.
      if (i > 0 && $urandom_range(0, 24) == 0) send_step();
      send_request(mlf_pkg::CMD_LOAD, POS_W'(perm[i]), pick_lcp(n, wide), i == n - 1);
    end
    texts_loaded++;
    if (n > longest_text) longest_text = n;
    full_walk = $urandom_range(0, 9) >= 2;
    steps_left = full_walk ? -1 : $urandom_range(0, 3);
    while (!sb.walk_done() && sb.step_is_safe() && steps_left != 0) begin
      send_step();
      steps_left--;
    end
    if (full_walk) repeat ($urandom_range(0, 2)) send_step();
  endtask

  task automatic send_noise();
    logic cmd;
    repeat ($urandom_range(1, 8)) begin
      cmd = 1'($urandom);
      if (cmd == mlf_pkg::CMD_LOAD)
        send_request(mlf_pkg::CMD_LOAD, POS_W'($urandom), LEN_W'($urandom),
                     $urandom_range(0, 4) == 0);
      else if (sb.step_is_safe())
        send_step();
    end
  endtask

  // Result side: bursts of stalls while idling is on, otherwise always ready.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no request moved for %0d cycles.", STALL_LIMIT);
    $display("match_length_factorizer: mismatch");
    $finish;
  end

  initial begin
    int budget;
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = mlf_pkg::CMD_LOAD;
    in_tlast = 1'b0;
    idling = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A step with no text loaded moves nothing.
    send_step();
    // Four ranks; the first rank's LCP is forced to zero and a step comes before the final rank.
    send_request(mlf_pkg::CMD_LOAD, 12'd2, 12'hFFF, 1'b0);
    send_request(mlf_pkg::CMD_LOAD, 12'd0, 12'd1, 1'b0);
    send_step();
    send_request(mlf_pkg::CMD_LOAD, 12'd3, 12'd0, 1'b0);
    send_request(mlf_pkg::CMD_LOAD, 12'd1, 12'd2, 1'b1);
    repeat (4) send_step();
    // One rank only: a zero match length still advances by one.
    send_request(mlf_pkg::CMD_LOAD, 12'd0, 12'd7, 1'b1);
    repeat (2) send_step();
    // Overlong matches clamp the cursor at the text length.
    send_request(mlf_pkg::CMD_LOAD, 12'd1, 12'd0, 1'b0);
    send_request(mlf_pkg::CMD_LOAD, 12'd0, 12'hFFF, 1'b0);
    send_request(mlf_pkg::CMD_LOAD, 12'd2, 12'hFFF, 1'b1);
    send_step();
    // A unit step, then a new text starts in the middle of the walk.
    send_request(mlf_pkg::CMD_LOAD, 12'd3, 12'd0, 1'b0);
    send_request(mlf_pkg::CMD_LOAD, 12'd0, 12'd0, 1'b0);
    send_request(mlf_pkg::CMD_LOAD, 12'd2, 12'd0, 1'b0);
    send_request(mlf_pkg::CMD_LOAD, 12'd1, 12'd0, 1'b1);
    send_step();
    send_request(mlf_pkg::CMD_LOAD, 12'hFFF, 12'd5, 1'b0);
    send_request(mlf_pkg::CMD_LOAD, 12'h800, 12'd9, 1'b1);

    budget = requests_sent + RANDOM_ITEMS;
    while (requests_sent < budget) begin
      idling = (budget - requests_sent > 120) && $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) < 7) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        load_and_walk(n, $urandom_range(0, 7) == 0);
      end else begin
        send_noise();
      end
    end
    in_tvalid = 1'b0;
    idling = 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests; %0d suffix arrays loaded and walked, the longest %0d ranks.",
             requests_sent, texts_loaded, longest_text);
    $display("Compared %0d results, %0d field mismatches, %0d results never arrived.",
             sb.checked, sb.errors, sb.owed_q.size());
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("match_length_factorizer: match");
    end else begin
      $display("match_length_factorizer: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mlf_pkg.sv
rtl/mlf_len_mem.sv
rtl/mlf_core.sv
rtl/match_length_factorizer.sv
tb/sv/tb_top.sv
